// ----- sv/b64lw_pkg.sv -----
// ----------------------------------------------------------------------------
// b64lw_pkg
// Types, constants and the character map shared by the base64 line-wrap
// encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

	localparam logic [7:0] CHAR_PAD     = 8'h3d;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam int         JOB_DEPTH    = 4;
	localparam int         JOB_PTR_W    = $clog2(JOB_DEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} result_t;

	// one group of up to three bytes waiting to be turned into characters
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
		logic        last;
	} job_t;

	typedef enum logic [1:0] {
		ST_CHAR,
		ST_WRAP,
		ST_CLOSE
	} back_state_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return w + 8'h41;
		end else if (v < 6'd52) begin
			return w + 8'h47;
		end else if (v < 6'd62) begin
			return w - 8'h04;
		end else if (v == 6'd62) begin
			return 8'h2b;
		end else begin
			return 8'h2f;
		end
	endfunction

endpackage

// ----- sv/b64lw_front.sv -----
// ----------------------------------------------------------------------------
// b64lw_front
// Gathers incoming bytes into groups of three and hands each finished or
// final group to the job queue.
// ----------------------------------------------------------------------------
module b64lw_front
	import b64lw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  item_t item,
	output logic  job_push,
	output job_t  job
);

	logic [1:0]  pos_q;
	logic [15:0] pend_q;
	logic [1:0]  pos_d;
	logic [15:0] pend_d;

	always_comb begin
		pos_d    = pos_q;
		pend_d   = pend_q;
		job_push = 1'b0;
		job      = '0;
		if (take) begin
			case (pos_q)
				2'd0: begin
					pend_d     = {item.data_byte, 8'h00};
					pos_d      = 2'd1;
					job.bits   = {item.data_byte, 16'h0000};
					job.nbytes = 2'd1;
					job_push   = item.last_byte;
				end
				2'd1: begin
					pend_d     = {pend_q[15:8], item.data_byte};
					pos_d      = 2'd2;
					job.bits   = {pend_q[15:8], item.data_byte, 8'h00};
					job.nbytes = 2'd2;
					job_push   = item.last_byte;
				end
				default: begin
					pend_d     = '0;
					pos_d      = 2'd0;
					job.bits   = {pend_q, item.data_byte};
					job.nbytes = 2'd3;
					job_push   = 1'b1;
				end
			endcase
			job.last = item.last_byte;
			if (item.last_byte) begin
				pend_d = '0;
				pos_d  = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			pend_q <= '0;
		end else begin
			pos_q  <= pos_d;
			pend_q <= pend_d;
		end
	end

endmodule

// ----- sv/b64lw_fifo.sv -----
// ----------------------------------------------------------------------------
// b64lw_fifo
// Short queue of group jobs between the byte front end and the character
// back end.
// ----------------------------------------------------------------------------
module b64lw_fifo
	import b64lw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	output logic full,
	input  logic rd_en,
	output job_t rd_data,
	output logic empty
);

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_PTR_W:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full    = (count_q == (JOB_PTR_W+1)'(JOB_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/b64lw_back.sv -----
// ----------------------------------------------------------------------------
// b64lw_back
// Turns one group job at a time into base64 characters, inserts wrap and
// closing newlines, and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
module b64lw_back
	import b64lw_pkg::*;
#(
	parameter int LINE_CHARS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_empty,
	input  job_t    job_in,
	output logic    job_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	localparam int COL_W = $clog2(LINE_CHARS);

	back_state_t st_q, st_d;
	job_t        job_q, job_d;
	logic        busy_q, busy_d;
	logic [1:0]  idx_q, idx_d;
	logic        wrap_q, wrap_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [COL_W:0]   col_inc;
	logic        hit;
	logic        emit;
	logic        done;
	result_t     res_d;
	result_t     out_q;
	logic        out_valid_q;
	logic        slot_free;
	logic [5:0]  sextet;
	logic        pad;
	logic [7:0]  char_sel;

	assign slot_free = !out_valid_q || pop;
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign hit       = (col_inc == (COL_W+1)'(LINE_CHARS));

	always_comb begin
		case (idx_q)
			2'd0:    sextet = job_q.bits[23:18];
			2'd1:    sextet = job_q.bits[17:12];
			2'd2:    sextet = job_q.bits[11:6];
			default: sextet = job_q.bits[5:0];
		endcase
		pad      = ((idx_q == 2'd2) && (job_q.nbytes < 2'd2)) ||
		           ((idx_q == 2'd3) && (job_q.nbytes < 2'd3));
		char_sel = pad ? CHAR_PAD : b64_char(sextet);
	end

	always_comb begin
		st_d    = st_q;
		job_d   = job_q;
		busy_d  = busy_q;
		idx_d   = idx_q;
		wrap_d  = wrap_q;
		col_d   = col_q;
		emit    = 1'b0;
		done    = 1'b0;
		job_pop = 1'b0;
		res_d   = '0;
		if (!busy_q) begin
			if (!job_empty) begin
				job_pop = 1'b1;
				job_d   = job_in;
				busy_d  = 1'b1;
				idx_d   = 2'd0;
				wrap_d  = 1'b0;
				st_d    = ST_CHAR;
			end
		end else if (slot_free) begin
			emit = 1'b1;
			case (st_q)
				ST_CHAR: begin
					res_d.out_char = char_sel;
					col_d          = hit ? '0 : col_inc[COL_W-1:0];
					if (hit) begin
						st_d = ST_WRAP;
					end else if (idx_q == 2'd3) begin
						if (job_q.last && !wrap_q) begin
							st_d = ST_CLOSE;
						end else begin
							res_d.out_last = 1'b1;
							done           = 1'b1;
						end
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				ST_WRAP: begin
					res_d.out_char = CHAR_NEWLINE;
					wrap_d         = 1'b1;
					if (idx_q == 2'd3) begin
						res_d.out_last = 1'b1;
						done           = 1'b1;
					end else begin
						idx_d = idx_q + 1'b1;
						st_d  = ST_CHAR;
					end
				end
				default: begin
					res_d.out_char = CHAR_NEWLINE;
					res_d.out_last = 1'b1;
					done           = 1'b1;
				end
			endcase
			if (done) begin
				busy_d = 1'b0;
				st_d   = ST_CHAR;
				if (job_q.last) begin
					col_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CHAR;
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			wrap_q      <= 1'b0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			busy_q <= busy_d;
			idx_q  <= idx_d;
			wrap_q <= wrap_d;
			col_q  <= col_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		job_q <= job_d;
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ----- sv/base64_encoder_line_wrap.sv -----
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Byte stream to base64 text: a newline after every LINE_CHARS characters,
// and a closing newline ending each stream whose last group had no wrap.
// ----------------------------------------------------------------------------
// Input side is a queue write port: item is taken when push is high and full
// is low. One byte per transfer; last_byte marks the end of a stream.
// Result side is a queue read port: while empty is low the oldest character
// is on result, and it leaves when pop is high. out_last marks the final
// character caused by one input byte.
// The front end takes one byte per cycle while the job queue is not full
// and queues one job per group of three bytes (or per final partial group)
// in a four-entry job queue. The back end emits one character per cycle
// from its output register while the reader does not stall, and loads each
// job in a step of its own in which it emits nothing. The first character of
// a group reaches result through the job queue, the job register and the
// output register after the byte that completes the group.
// A stalled reader stops the back end; the front end keeps taking bytes
// until the job queue fills, then holds full high.
// Reset clears the group position, pending bytes, line column, job queue
// and output valid flag; the next byte starts a fresh stream.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap
	import b64lw_pkg::*;
#(
	parameter int LINE_CHARS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic job_push;
	job_t job_wr;
	logic job_full;
	logic job_pop;
	job_t job_rd;
	logic job_empty;

	assign full = job_full;

	b64lw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (push && !job_full),
		.item     (item),
		.job_push (job_push),
		.job      (job_wr)
	);

	b64lw_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_wr),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_rd),
		.empty   (job_empty)
	);

	b64lw_back #(
		.LINE_CHARS (LINE_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_in    (job_rd),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// ----- sv/b64lw_checker.sv -----
// ----------------------------------------------------------------------------
// b64lw_checker
// Port-level checks for the base64 line-wrap encoder.
// ----------------------------------------------------------------------------
module b64lw_checker
	import b64lw_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    push,
	input logic    full,
	input item_t   item,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	logic legal_char;

	assign legal_char = ((result.out_char >= 8'h41) && (result.out_char <= 8'h5a)) ||
	                    ((result.out_char >= 8'h61) && (result.out_char <= 8'h7a)) ||
	                    ((result.out_char >= 8'h30) && (result.out_char <= 8'h39)) ||
	                    (result.out_char == 8'h2b) || (result.out_char == 8'h2f) ||
	                    (result.out_char == CHAR_PAD) || (result.out_char == CHAR_NEWLINE);

	// stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	// nothing waits in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> legal_char)
		else $error("character outside base64 text set");

	// padding never opens a group, so a pad before a step's end is followed by a pad or newline
	a_pad_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && result.out_char == CHAR_PAD && !result.out_last |=>
		empty || result.out_char == CHAR_PAD || result.out_char == CHAR_NEWLINE)
		else $error("text character after padding within one step");

	// accepted transfer carries a known byte
	a_known_in: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |-> !$isunknown(item))
		else $error("unknown item accepted");

endmodule

bind base64_encoder_line_wrap b64lw_checker u_b64lw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// ----- tb/base64_encoder_line_wrap_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap_test
// Self-checking bench for the base64 line-wrap encoder: byte streams go in,
// and every character, pad and newline that comes out is compared with a
// predicted copy of the wrapped text, including the end-of-transfer marks.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap_test;
	import b64lw_pkg::*;

	localparam int LINE_CHARS = 64;
	localparam int MAX_PER_BYTE = 5;
	localparam logic [8*64-1:0] SYMBOLS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	class b64_text_scoreboard;
		logic [15:0] held_bytes;
		logic [1:0]  held_count;
		int unsigned column;
		logic [7:0]  step_chars[$];
		result_t     due_chars[$];
		int unsigned bytes_taken;
		int unsigned chars_checked;
		int unsigned wraps_seen;
		int unsigned mismatches;

		function new();
			held_bytes = '0;
			held_count = '0;
			column = 0;
			bytes_taken = 0;
			chars_checked = 0;
			wraps_seen = 0;
			mismatches = 0;
		endfunction

		function logic [7:0] b64_sym(logic [5:0] v);
			return SYMBOLS[8*(63-v) +: 8];
		endfunction

		function void emit(logic [7:0] c);
			if (step_chars.size() < MAX_PER_BYTE)
				step_chars.push_back(c);
		endfunction

		function void emit_text(logic [7:0] c);
			emit(c);
			column++;
			if (column >= LINE_CHARS) begin
				emit(CHAR_NEWLINE);
				column = 0;
				wraps_seen++;
			end
		endfunction

		function void emit_group(logic [23:0] v, int n);
			emit_text(b64_sym(v[23:18]));
			emit_text(b64_sym(v[17:12]));
			emit_text(n > 1 ? b64_sym(v[11:6]) : CHAR_PAD);
			emit_text(n > 2 ? b64_sym(v[5:0]) : CHAR_PAD);
		endfunction

		// note one accepted byte and queue the characters it causes
		function void take_byte(item_t it);
			result_t r;
			step_chars.delete();
			if (held_count >= 2) begin
				emit_group({held_bytes, it.data_byte}, 3);
				held_bytes = '0;
				held_count = 2'd0;
			end else if (held_count == 1) begin
				held_bytes[7:0] = it.data_byte;
				held_count = 2'd2;
				if (it.last_byte)
					emit_group({held_bytes, 8'h00}, 2);
			end else begin
				held_bytes = {it.data_byte, 8'h00};
				held_count = 2'd1;
				if (it.last_byte)
					emit_group({it.data_byte, 16'h0000}, 1);
			end
			if (it.last_byte) begin
				if (column != 0)
					emit(CHAR_NEWLINE);
				held_bytes = '0;
				held_count = 2'd0;
				column = 0;
			end
			foreach (step_chars[i]) begin
				r.out_char = step_chars[i];
				r.out_last = (i == step_chars.size() - 1);
				due_chars.push_back(r);
			end
			bytes_taken++;
		endfunction

		function void check_char(result_t got);
			result_t want;
			if (due_chars.size() == 0) begin
				$error("out_char: expected none, actual %h", got.out_char);
				mismatches++;
				return;
			end
			want = due_chars.pop_front();
			chars_checked++;
			if (got.out_char !== want.out_char) begin
				$error("out_char: expected %h, actual %h", want.out_char, got.out_char);
				mismatches++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last: expected %b, actual %b", want.out_last, got.out_last);
				mismatches++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;
	bit      quiet = 1'b0;
	int      streams_sent = 0;

	b64_text_scoreboard sb = new();

	base64_encoder_line_wrap #(
		.LINE_CHARS(LINE_CHARS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_char(result);
	end

	// reader side with stall bursts
	initial begin : reader
		int stall_left;
		stall_left = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 19);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		item_t it;
		int gap;
		it.data_byte = b;
		it.last_byte = fin;
		gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sb.take_byte(it);
		if (fin)
			streams_sent++;
	endtask

	task automatic send_stream(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	// hold the sender off until every queued character has been read
	task automatic drain_pause();
		@(negedge clk);
		push <= 1'b0;
		while (sb.due_chars.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int random_bytes;
		int len;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hfb, 1'b0);
		send_byte(8'hef, 1'b0);
		send_byte(8'hbe, 1'b1);
		send_byte(8'h4d, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6e, 1'b0);
		send_byte(8'h01, 1'b1);
		drain_pause();

		// exactly one full line, so the wrap lands on the final group
		send_stream(48);
		random_bytes = int'(sb.bytes_taken);
		while (random_bytes < 110) begin
			if ($urandom_range(0, 3) == 0)
				len = $urandom_range(45, 56);
			else
				len = $urandom_range(1, 9);
			if (len > 110 - random_bytes)
				len = 110 - random_bytes;
			if (random_bytes > 70 && !quiet) begin
				drain_pause();
				quiet = 1'b1;
			end
			send_stream(len);
			random_bytes += len;
		end

		@(negedge clk);
		push <= 1'b0;
		while (sb.due_chars.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d streams, %0d bytes in, %0d characters checked",
			streams_sent, sb.bytes_taken, sb.chars_checked);
		$display("%0d line wraps predicted, including one on a final group", sb.wraps_seen);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
